// ===== sv/i2cw_pkg.sv =====
`default_nettype none

package i2cw_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned TickWidth   = 16;
  localparam int unsigned BitIdxWidth = 4;

  localparam logic [TickWidth-1:0] HalfPeriodReset = 16'd10;
  localparam logic [TickWidth-1:0] HalfPeriodMin   = 16'd1;

  localparam logic [0:0] OpTick = 1'b0;
  localparam logic [0:0] OpLoad = 1'b1;

  localparam logic RegIdxHalfPeriod = 1'b0;

  typedef struct packed {
    logic                   operation;
    logic [BitsPerByte-1:0] tx_byte;
    logic                   first_byte;
    logic                   last_byte;
    logic                   sda_in;
  } in_item_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic busy_res;
    logic nack_seen;
    logic byte_done;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_LOAD_START,
    CMD_LOAD_CONT
  } cmd_e;

  typedef struct packed {
    cmd_e                   cmd;
    logic [BitsPerByte-1:0] tx_byte;
    logic                   last_byte;
    logic                   sda_in;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/i2cw_front.sv =====
`default_nettype none

module i2cw_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  i2cw_pkg::in_item_t item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output i2cw_pkg::cmd_t    cmd_o
);
  import i2cw_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.tx_byte   = item_i.tx_byte;
    cmd_in.last_byte = item_i.last_byte;
    cmd_in.sda_in    = item_i.sda_in;
    if (item_i.operation == OpTick) begin
      cmd_in.cmd = CMD_TICK;
    end else if (item_i.first_byte) begin
      cmd_in.cmd = CMD_LOAD_START;
    end else begin
      cmd_in.cmd = CMD_LOAD_CONT;
    end
  end

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/i2cw_out_q.sv =====
`default_nettype none

module i2cw_out_q (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  i2cw_pkg::out_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output i2cw_pkg::out_item_t item_o
);
  import i2cw_pkg::*;

  out_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/i2cw_engine.sv =====
`default_nettype none

module i2cw_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [i2cw_pkg::TickWidth-1:0]    half_period_i,
  input  logic                              cmd_valid_i,
  input  i2cw_pkg::cmd_t                    cmd_i,
  output logic                              cmd_pop_o,
  input  logic                              res_full_i,
  output logic                              res_push_o,
  output i2cw_pkg::out_item_t               res_o
);
  import i2cw_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_A,
    PH_START_B,
    PH_BIT_LOW,
    PH_BIT_HIGH,
    PH_ACK_LOW,
    PH_ACK_HIGH,
    PH_STOP_A,
    PH_STOP_B,
    PH_STOP_C,
    PH_WAIT
  } phase_e;

  phase_e                 phase_q, phase_d, target;
  logic [BitIdxWidth-1:0] bit_q, bit_d;
  logic [TickWidth-1:0]   dcnt_q, dcnt_d, dcnt_inc, hp_eff;
  logic [BitsPerByte-1:0] shift_q, shift_d;
  logic                   last_q, last_d;
  logic                   abort_q, abort_d;
  logic                   nack_q, nack_d;
  logic                   scl_q, scl_d, sda_q, sda_d;
  logic                   go, done, busy;
  logic                   fire;

  assign fire       = cmd_valid_i && !res_full_i;
  assign cmd_pop_o  = fire;
  assign res_push_o = fire;
  assign hp_eff     = (half_period_i == '0) ? HalfPeriodMin : half_period_i;
  assign busy       = (phase_q != PH_IDLE) && (phase_q != PH_WAIT);
  assign dcnt_inc   = dcnt_q + HalfPeriodMin;

  always_comb begin
    phase_d = phase_q;
    bit_d   = bit_q;
    dcnt_d  = dcnt_q;
    shift_d = shift_q;
    last_d  = last_q;
    abort_d = abort_q;
    nack_d  = nack_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    go      = 1'b0;
    done    = 1'b0;
    target  = PH_IDLE;

    if (cmd_i.cmd != CMD_TICK) begin
      if (!busy) begin
        if (cmd_i.cmd == CMD_LOAD_START) begin
          abort_d = 1'b0;
        end
        if (cmd_i.cmd == CMD_LOAD_START || !abort_q) begin
          shift_d = cmd_i.tx_byte;
          last_d  = cmd_i.last_byte;
          bit_d   = '0;
          go      = 1'b1;
          target  = (cmd_i.cmd == CMD_LOAD_START) ? PH_START_A : PH_BIT_LOW;
        end
      end
    end else if (busy) begin
      dcnt_d = dcnt_inc;
      if (dcnt_inc >= hp_eff) begin
        go = 1'b1;
        unique case (phase_q)
          PH_START_A:  target = PH_START_B;
          PH_START_B: begin
            bit_d  = '0;
            target = PH_BIT_LOW;
          end
          PH_BIT_LOW:  target = PH_BIT_HIGH;
          PH_BIT_HIGH: begin
            bit_d  = bit_q + 1'b1;
            target = (bit_d < BitIdxWidth'(BitsPerByte)) ? PH_BIT_LOW : PH_ACK_LOW;
          end
          PH_ACK_LOW:  target = PH_ACK_HIGH;
          PH_ACK_HIGH: begin
            nack_d = cmd_i.sda_in;
            done   = 1'b1;
            if (cmd_i.sda_in) begin
              abort_d = 1'b1;
              target  = PH_STOP_A;
            end else if (last_q) begin
              target = PH_STOP_A;
            end else begin
              target = PH_WAIT;
            end
          end
          PH_STOP_A:   target = PH_STOP_B;
          PH_STOP_B:   target = PH_STOP_C;
          default:     target = PH_IDLE;
        endcase
      end
    end

    if (go) begin
      phase_d = target;
      dcnt_d  = '0;
      unique case (target)
        PH_START_A: begin
          scl_d = 1'b1;
          sda_d = 1'b1;
        end
        PH_START_B:  sda_d = 1'b0;
        PH_BIT_LOW: begin
          scl_d = 1'b0;
          sda_d = (bit_d < BitIdxWidth'(BitsPerByte))
                ? shift_d[3'(BitsPerByte - 1) - bit_d[2:0]] : 1'b1;
        end
        PH_BIT_HIGH: scl_d = 1'b1;
        PH_ACK_LOW: begin
          scl_d = 1'b0;
          sda_d = 1'b1;
        end
        PH_ACK_HIGH: scl_d = 1'b1;
        PH_STOP_A: begin
          scl_d = 1'b0;
          sda_d = 1'b0;
        end
        PH_STOP_B:   scl_d = 1'b1;
        PH_STOP_C:   sda_d = 1'b1;
        default: begin
          scl_d = 1'b1;
          sda_d = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    res_o.scl_level = scl_d;
    res_o.sda_level = sda_d;
    res_o.busy_res  = (phase_d != PH_IDLE) && (phase_d != PH_WAIT);
    res_o.nack_seen = nack_d;
    res_o.byte_done = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bit_q   <= '0;
      dcnt_q  <= '0;
      shift_q <= '0;
      last_q  <= 1'b0;
      abort_q <= 1'b0;
      nack_q  <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else if (fire) begin
      phase_q <= phase_d;
      bit_q   <= bit_d;
      dcnt_q  <= dcnt_d;
      shift_q <= shift_d;
      last_q  <= last_d;
      abort_q <= abort_d;
      nack_q  <= nack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
    end
  end

  a_done_from_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_o.byte_done |-> phase_q == PH_ACK_HIGH)
    else $error("byte done outside acknowledge phase");

  a_start_sda_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_START_B |-> scl_q && !sda_q)
    else $error("start condition pins wrong");

  a_scl_low_phases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BIT_LOW || phase_q == PH_ACK_LOW || phase_q == PH_STOP_A |-> !scl_q)
    else $error("SCL released in a low phase");

  a_ack_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ACK_LOW || phase_q == PH_ACK_HIGH |-> sda_q)
    else $error("SDA driven during acknowledge");

endmodule

`default_nettype wire

// ===== sv/i2c_master_byte_writer_core.sv =====
// Channel  | Handshake          | Payload
// input    | push / full        | in_item_i  (operation, tx_byte, first_byte, last_byte, sda_in)
// result   | empty / pop        | out_item_o (scl_level, sda_level, busy_res, nack_seen, byte_done)
// config   | APB write, pready=1| half_period_ticks at byte address 0
//
// One item per clock sustained while the result queue has room; an accepted item waits in
// the input queue until the engine takes it, and its result is written to the result queue.
// The bit engine updates its phase state once per item, which sets that rate.
// Two-entry queues sit on both sides of the engine; each side stalls on its own.
// Reset brings both lines released, the engine idle and half_period_ticks at 10.
`default_nettype none

module i2c_master_byte_writer_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  i2cw_pkg::in_item_t  in_item_i,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output i2cw_pkg::out_item_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import i2cw_pkg::*;

  logic [TickWidth-1:0] half_period_q;
  logic                 cfg_wr;
  logic                 cmd_empty, cmd_pop;
  cmd_t                 cmd;
  logic                 res_full, res_push;
  out_item_t            res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegIdxHalfPeriod);
  assign prdata = (paddr[2] == RegIdxHalfPeriod)
                ? {{(32 - TickWidth){1'b0}}, half_period_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HalfPeriodReset;
    end else if (cfg_wr) begin
      half_period_q <= pwdata[TickWidth-1:0];
    end
  end

  i2cw_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item_i),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .cmd_o   (cmd)
  );

  i2cw_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .half_period_i (half_period_q),
    .cmd_valid_i   (!cmd_empty),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .res_full_i    (res_full),
    .res_push_o    (res_push),
    .res_o         (res)
  );

  i2cw_out_q u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .item_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== tb/i2c_master_byte_writer_core_tb.sv =====
`default_nettype none

module i2c_master_byte_writer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cw_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int NumPhases = 7;
  localparam logic [2:0] HalfPeriodAddr = {RegIdxHalfPeriod, 2'b00};

  typedef enum logic [3:0] {
    BUS_IDLE,
    BUS_START_HI,
    BUS_START_LO,
    BUS_BIT_LO,
    BUS_BIT_HI,
    BUS_ACK_LO,
    BUS_ACK_HI,
    BUS_STOP_LO,
    BUS_STOP_SCL,
    BUS_STOP_SDA,
    BUS_HOLD
  } bus_phase_e;

  typedef struct {
    logic       op;
    logic [7:0] tx;
    logic       first_b;
    logic       last_b;
    logic       sda;
    int         reps;
    bit         typed;
    out_item_t  want;
    int         new_hp;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  in_item_t    item_in = '0;
  logic        full;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   item_out;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bus_phase_e      eng_phase = BUS_IDLE;
  logic [3:0]      eng_bit = '0;
  logic [15:0]     eng_delay = '0;
  logic [7:0]      eng_shift = '0;
  logic            eng_last = 1'b0;
  logic            eng_abort = 1'b0;
  logic            eng_nack = 1'b0;
  logic            eng_scl = 1'b1;
  logic            eng_sda = 1'b1;
  logic [15:0]     half_period = HalfPeriodReset;

  out_item_t expect_q[$];
  int        errors = 0;
  int        popped = 0;
  int        cycle_count = 0;
  int        gap_pct = 10;
  int        items_left = 0;
  bit        steady = 1'b0;
  bit        pressed = 1'b0;

  string field_name [5] = '{"scl_level", "sda_level", "busy_res", "nack_seen", "byte_done"};

  logic [15:0] hp_plan   [NumPhases] = '{16'd1, 16'd2, 16'd3, 16'hFFFF, 16'd0, 16'd5, 16'd1};
  int          size_plan [NumPhases] = '{110, 100, 100, 12, 90, 90, 100};
  int          gap_plan  [NumPhases] = '{15, 30, 0, 10, 25, 5, 0};

  dir_row_t plan [10] = '{
    '{OpTick, 8'h00, 1'b0, 1'b0, 1'b0, 1,  1'b1, 5'b11000, -1},
    '{OpLoad, 8'hFF, 1'b0, 1'b0, 1'b0, 1,  1'b1, 5'b01100, -1},
    '{OpLoad, 8'h00, 1'b1, 1'b1, 1'b0, 1,  1'b1, 5'b01100, -1},
    '{OpTick, 8'h00, 1'b0, 1'b0, 1'b0, 0,  1'b0, 5'b00000, 0},
    '{OpTick, 8'h00, 1'b0, 1'b0, 1'b0, 17, 1'b0, 5'b00000, -1},
    '{OpTick, 8'h00, 1'b0, 1'b0, 1'b1, 1,  1'b1, 5'b00111, -1},
    '{OpTick, 8'h00, 1'b0, 1'b0, 1'b0, 2,  1'b0, 5'b00000, -1},
    '{OpTick, 8'h00, 1'b0, 1'b0, 1'b0, 1,  1'b1, 5'b11010, -1},
    '{OpLoad, 8'h00, 1'b0, 1'b0, 1'b1, 1,  1'b1, 5'b11010, -1},
    '{OpLoad, 8'h00, 1'b1, 1'b1, 1'b0, 1,  1'b1, 5'b11110, -1}
  };

  i2c_master_byte_writer_core DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .in_item_i (item_in),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(item_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == CycleLimit);
    $display("FAIL");
    $finish;
  end

  function automatic void enter_phase(bus_phase_e ph);
    eng_phase = ph;
    eng_delay = '0;
    case (ph)
      BUS_START_HI, BUS_HOLD: begin
        eng_scl = 1'b1;
        eng_sda = 1'b1;
      end
      BUS_START_LO: eng_sda = 1'b0;
      BUS_BIT_LO: begin
        eng_scl = 1'b0;
        eng_sda = (eng_bit < BitsPerByte) ? eng_shift[BitsPerByte - 1 - eng_bit] : 1'b1;
      end
      BUS_BIT_HI, BUS_ACK_HI, BUS_STOP_SCL: eng_scl = 1'b1;
      BUS_ACK_LO: begin
        eng_scl = 1'b0;
        eng_sda = 1'b1;
      end
      BUS_STOP_LO: begin
        eng_scl = 1'b0;
        eng_sda = 1'b0;
      end
      BUS_STOP_SDA: eng_sda = 1'b1;
      default: begin
        eng_phase = BUS_IDLE;
        eng_scl = 1'b1;
        eng_sda = 1'b1;
      end
    endcase
  endfunction

  function automatic out_item_t step_engine(in_item_t it);
    logic        done;
    logic        busy;
    logic [15:0] hp_eff;
    done = 1'b0;
    busy = (eng_phase != BUS_IDLE) && (eng_phase != BUS_HOLD);
    if (it.operation == OpLoad) begin
      if (!busy) begin
        if (it.first_byte) eng_abort = 1'b0;
        if (!eng_abort) begin
          eng_shift = it.tx_byte;
          eng_last = it.last_byte;
          eng_bit = '0;
          enter_phase(it.first_byte ? BUS_START_HI : BUS_BIT_LO);
        end
      end
    end else if (busy) begin
      hp_eff = (half_period == '0) ? HalfPeriodMin : half_period;
      eng_delay = eng_delay + 16'd1;
      if (eng_delay >= hp_eff) begin
        case (eng_phase)
          BUS_START_HI: enter_phase(BUS_START_LO);
          BUS_START_LO: begin
            eng_bit = '0;
            enter_phase(BUS_BIT_LO);
          end
          BUS_BIT_LO: enter_phase(BUS_BIT_HI);
          BUS_BIT_HI: begin
            eng_bit = eng_bit + 4'd1;
            enter_phase((eng_bit < BitsPerByte) ? BUS_BIT_LO : BUS_ACK_LO);
          end
          BUS_ACK_LO: enter_phase(BUS_ACK_HI);
          BUS_ACK_HI: begin
            eng_nack = it.sda_in;
            done = 1'b1;
            if (eng_nack) begin
              eng_abort = 1'b1;
              enter_phase(BUS_STOP_LO);
            end else if (eng_last) begin
              enter_phase(BUS_STOP_LO);
            end else begin
              enter_phase(BUS_HOLD);
            end
          end
          BUS_STOP_LO: enter_phase(BUS_STOP_SCL);
          BUS_STOP_SCL: enter_phase(BUS_STOP_SDA);
          default: enter_phase(BUS_IDLE);
        endcase
      end
    end
    busy = (eng_phase != BUS_IDLE) && (eng_phase != BUS_HOLD);
    return '{eng_scl, eng_sda, busy, eng_nack, done};
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (expect_q.size() == 0) begin
      $display("%0t: result with none expected, actual %b", $time, got);
      errors++;
      return;
    end
    want = expect_q.pop_front();
    for (int i = 0; i < $bits(out_item_t); i++) begin
      if (got[$bits(out_item_t) - 1 - i] !== want[$bits(out_item_t) - 1 - i]) begin
        $display("%0t: %s expected %b actual %b", $time, field_name[i],
                 want[$bits(out_item_t) - 1 - i], got[$bits(out_item_t) - 1 - i]);
        errors++;
      end
    end
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t res;
    push <= 1'b1;
    item_in <= it;
    do @(posedge clk_i); while (full);
    res = step_engine(it);
    expect_q.push_back(typed ? want : res);
  endtask

  task automatic idle_gap();
    if (!steady && $urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_half_period(input logic [15:0] value);
    logic [31:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= HalfPeriodAddr;
    pwdata <= {16'h0000, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    half_period = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rd = prdata;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[15:0] !== value) begin
      $display("%0t: half_period_ticks expected %h actual %h", $time, value, rd[15:0]);
      errors++;
    end
  endtask

  task automatic run_message();
    int          nbytes;
    int          ticks;
    int          hp_eff;
    logic        first_b;
    logic        last_b;
    nbytes = $urandom_range(1, 4);
    hp_eff = (half_period == '0) ? 1 : int'(half_period);
    for (int b = 0; b < nbytes && items_left > 0; b++) begin
      first_b = (b == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 15) == 0);
      last_b = (b == nbytes - 1) ? ($urandom_range(0, 9) != 0) : 1'b0;
      send_item(in_item_t'{OpLoad, 8'($urandom), first_b, last_b, 1'($urandom)}, 1'b0, '0);
      items_left--;
      idle_gap();
      ticks = ((first_b ? 2 : 0) + 20 + (last_b ? 3 : 0)) * hp_eff;
      case ($urandom_range(0, 9))
        0: ticks = $urandom_range(0, ticks);
        1: ticks = ticks + $urandom_range(1, 6);
        default: ;
      endcase
      if (ticks > items_left) ticks = items_left;
      for (int t = 0; t < ticks; t++) begin
        if ($urandom_range(0, 24) == 0) begin
          send_item(in_item_t'{OpLoad, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)},
                    1'b0, '0);
        end else begin
          send_item(in_item_t'{OpTick, 8'($urandom), 1'($urandom), 1'($urandom),
                               1'($urandom_range(0, 7) == 0)}, 1'b0, '0);
          items_left--;
        end
        idle_gap();
      end
    end
  endtask

  initial begin : drain_results
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        check_result(item_out);
        popped++;
      end
      if (popped == 150 && !pressed) begin
        pressed = 1'b1;
        stall_left = 80;
      end else if (stall_left == 0 && !steady && $urandom_range(0, 99) < gap_pct) begin
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (plan[r]) begin
      if (plan[r].new_hp >= 0) begin
        push <= 1'b0;
        wait_drained();
        write_half_period(16'(plan[r].new_hp));
      end else begin
        for (int k = 0; k < plan[r].reps; k++) begin
          send_item(in_item_t'{plan[r].op, plan[r].tx, plan[r].first_b, plan[r].last_b,
                               plan[r].sda}, plan[r].typed, plan[r].want);
          idle_gap();
        end
      end
    end
    for (int p = 0; p < NumPhases; p++) begin
      push <= 1'b0;
      wait_drained();
      write_half_period(hp_plan[p]);
      steady = (p == NumPhases - 1);
      gap_pct = gap_plan[p];
      items_left = size_plan[p];
      while (items_left > 0) run_message();
    end
    push <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
